[rtl/core/mapp_pkg.sv]
package mapp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 32;
    localparam int unsigned HalfW  = 16;
    localparam int unsigned KindW  = 3;
    localparam int unsigned OutDataW = 2 * WordW;

    typedef enum logic [6:0] {
        PH_VERSION   = 7'b0000001,
        PH_TOPIC_CNT = 7'b0000010,
        PH_NAME_LEN  = 7'b0000100,
        PH_NAME      = 7'b0001000,
        PH_PART_CNT  = 7'b0010000,
        PH_PART      = 7'b0100000,
        PH_DONE      = 7'b1000000
    } t_phase;

    typedef enum logic [KindW-1:0] {
        K_VERSION   = 3'd0,
        K_NAME      = 3'd1,
        K_PART      = 3'd2,
        K_MALFORMED = 3'd3,
        K_COMPLETE  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } t_in_word;

    typedef struct packed {
        logic             have;
        t_kind            kind;
        logic [WordW-1:0] value;
        logic [WordW-1:0] topic;
        logic             last;
    } t_result;

endpackage

[rtl/core/mapp_in_reg.sv]
module mapp_in_reg
    import mapp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

[rtl/core/mapp_core.sv]
module mapp_core
    import mapp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_word i_word,
    output t_result  o_result
);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_cnt, n_cnt;
    logic [WordW-1:0] r_acc, n_acc;
    logic [WordW-1:0] r_topics, n_topics;
    logic [WordW-1:0] r_parts, n_parts;
    logic [HalfW-1:0] r_name, n_name;
    logic [WordW-1:0] r_tnum, n_tnum;

    logic [WordW-1:0] acc_sh;
    logic             done2;
    logic             done4;
    logic [WordW-1:0] topics_dec;
    logic [WordW-1:0] parts_dec;
    logic [HalfW-1:0] name_dec;
    t_phase           fin_phase;
    t_result          res;

    assign acc_sh     = {r_acc[WordW-ByteW-1:0], i_word.data};
    assign done2      = (r_cnt != 2'd0);
    assign done4      = (r_cnt == 2'd3);
    assign topics_dec = r_topics - WordW'(1);
    assign parts_dec  = r_parts - WordW'(1);
    assign name_dec   = r_name - HalfW'(1);
    assign fin_phase  = (topics_dec == '0) ? PH_DONE : PH_NAME_LEN;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_topics = r_topics;
        n_parts  = r_parts;
        n_name   = r_name;
        n_tnum   = r_tnum;
        res      = '{have: 1'b0, kind: K_VERSION, value: '0, topic: '0,
                     last: i_word.last};

        unique case (r_phase)
            PH_VERSION: begin
                n_acc = done2 ? '0 : acc_sh;
                n_cnt = done2 ? 2'd0 : r_cnt + 2'd1;
                if (done2) begin
                    res.have  = 1'b1;
                    res.kind  = K_VERSION;
                    res.value = {{(WordW-HalfW){1'b0}}, acc_sh[HalfW-1:0]};
                    n_phase   = PH_TOPIC_CNT;
                end
            end
            PH_TOPIC_CNT: begin
                n_acc = done4 ? '0 : acc_sh;
                n_cnt = done4 ? 2'd0 : r_cnt + 2'd1;
                if (done4) begin
                    n_topics = acc_sh;
                    n_tnum   = '0;
                    n_phase  = (acc_sh == '0) ? PH_DONE : PH_NAME_LEN;
                end
            end
            PH_NAME_LEN: begin
                n_acc = done2 ? '0 : acc_sh;
                n_cnt = done2 ? 2'd0 : r_cnt + 2'd1;
                if (done2) begin
                    n_name  = acc_sh[HalfW-1:0];
                    n_phase = (acc_sh[HalfW-1:0] == '0) ? PH_PART_CNT : PH_NAME;
                end
            end
            PH_NAME: begin
                res.have  = 1'b1;
                res.kind  = K_NAME;
                res.value = {{(WordW-ByteW){1'b0}}, i_word.data};
                res.topic = r_tnum;
                n_name    = name_dec;
                if (name_dec == '0) begin
                    n_phase = PH_PART_CNT;
                end
            end
            PH_PART_CNT: begin
                n_acc = done4 ? '0 : acc_sh;
                n_cnt = done4 ? 2'd0 : r_cnt + 2'd1;
                if (done4) begin
                    n_parts = acc_sh;
                    if (acc_sh == '0) begin
                        n_tnum   = r_tnum + WordW'(1);
                        n_topics = topics_dec;
                        n_phase  = fin_phase;
                    end else begin
                        n_phase = PH_PART;
                    end
                end
            end
            PH_PART: begin
                n_acc = done4 ? '0 : acc_sh;
                n_cnt = done4 ? 2'd0 : r_cnt + 2'd1;
                if (done4) begin
                    res.have  = 1'b1;
                    res.kind  = K_PART;
                    res.value = acc_sh;
                    res.topic = r_tnum;
                    n_parts   = parts_dec;
                    if (parts_dec == '0) begin
                        n_tnum   = r_tnum + WordW'(1);
                        n_topics = topics_dec;
                        n_phase  = fin_phase;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (i_word.last) begin
            if (n_phase != PH_DONE) begin
                res.have  = 1'b1;
                res.kind  = K_MALFORMED;
                res.value = '0;
                res.topic = '0;
            end else if (!res.have) begin
                res.have  = 1'b1;
                res.kind  = K_COMPLETE;
                res.value = '0;
                res.topic = '0;
            end
            n_phase  = PH_VERSION;
            n_cnt    = '0;
            n_acc    = '0;
            n_topics = '0;
            n_parts  = '0;
            n_name   = '0;
            n_tnum   = '0;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_VERSION;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_topics <= '0;
            r_parts  <= '0;
            r_name   <= '0;
            r_tnum   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_topics <= n_topics;
            r_parts  <= n_parts;
            r_name   <= n_name;
            r_tnum   <= n_tnum;
        end
    end

endmodule

[rtl/core/mapp_out_reg.sv]
module mapp_out_reg
    import mapp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.have;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.have) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/core/member_assignment_parser.sv]
// Member assignment parser.
// Input stream: one message byte per word on s_axis_tdata[7:0], s_axis_tlast
// on the final byte. Output stream: one word per emitted item, m_axis_tuser
// gives the kind (version, name byte, partition, malformed, complete),
// m_axis_tdata carries the value in [31:0] and the topic index in [63:32],
// m_axis_tlast marks the last result of a message.
// Path: a byte taken into the input register passes through the parse logic
// into the output register, which then presents its result.
// Throughput: one byte per cycle while the output register is free, with no
// gaps between messages; bytes that produce no result are accepted likewise.
// Stall: when m_axis_tready is low with a result pending, the input register
// holds at most one more byte; after that s_axis_tready drops until the
// output register is freed. No word is dropped or repeated.
// Reset (i_rst_n low, synchronous): both registers empty, parser back to
// expecting the version field of a new message.
module member_assignment_parser
    import mapp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tlast,   // last_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // [31:0] value, [63:32] topic_number
    output logic [KindW-1:0]    m_axis_tuser,   // [2:0] kind
    output logic                m_axis_tlast    // message_end
);

    t_in_word in_word;
    t_in_word stage_word;
    logic     stage_valid;
    logic     out_free;
    logic     advance;
    t_result  core_res;
    t_result  out_res;

    assign in_word = '{data: s_axis_tdata, last: s_axis_tlast};
    assign advance = stage_valid && out_free;

    mapp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_word    (in_word),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_word    (stage_word)
    );

    mapp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (stage_word),
        .o_result (core_res)
    );

    mapp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_res),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_res)
    );

    assign m_axis_tdata = {out_res.topic, out_res.value};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

[rtl/core/mapp_checker.sv]
module mapp_checker
    import mapp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata,
    input logic [KindW-1:0]    m_axis_tuser,
    input logic                m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_MALFORMED || m_axis_tuser == K_COMPLETE)
            |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("end-of-message word malformed");

    a_version_topic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == K_VERSION |->
            m_axis_tdata[OutDataW-1:HalfW] == '0)
        else $error("version word carries stray bits");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind member_assignment_parser mapp_checker u_mapp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[bench/member_assignment_parser_test.sv]
`timescale 1ns / 100ps

module member_assignment_parser_test;
    import mapp_pkg::*;

    localparam int RandomWords = 400;

    // one input word, plus its expected result where it is typed in by hand
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
        logic             typed;
        logic             have;
        t_kind            kind;
        logic [WordW-1:0] value;
        logic [WordW-1:0] topic;
    } t_row;

    localparam t_row DIRECTED [0:25] = '{
        // extremes: version 0xFFFF, one topic, one name byte, partition all ones, ends on it
        '{8'hFF, 1'b0, 1'b1, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, K_VERSION,   32'h0000_FFFF, 32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h01, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h01, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'hA5, 1'b0, 1'b1, 1'b1, K_NAME,      32'h0000_00A5, 32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h01, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, K_PART,      32'hFFFF_FFFF, 32'h0},
        // version 0, zero topics, one trailing word ignored, then complete
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'h5A, 1'b0, 1'b1, 1'b0, K_VERSION,   32'h0,         32'h0},
        '{8'hC3, 1'b1, 1'b1, 1'b1, K_COMPLETE,  32'h0,         32'h0},
        // message cut short in the version field
        '{8'h12, 1'b1, 1'b1, 1'b1, K_MALFORMED, 32'h0,         32'h0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [ByteW-1:0]    s_axis_tdata;   // [7:0] data_byte
    logic                s_axis_tlast;   // last_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;   // [31:0] value, [63:32] topic_number
    logic [KindW-1:0]    m_axis_tuser;   // [2:0] kind
    logic                m_axis_tlast;   // message_end

    member_assignment_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_row             msg_words[$];
    logic [ByteW-1:0] msg_q[$];
    t_result          results_due[$];
    int               words_taken;
    int               errors;
    int               send_rush;

    // parser mirror
    t_phase           parse_ph;
    logic [1:0]       field_cnt;
    logic [WordW-1:0] acc;
    logic [WordW-1:0] topics_left;
    logic [WordW-1:0] parts_left;
    logic [HalfW-1:0] name_left;
    logic [WordW-1:0] topic_idx;

    function automatic void clear_parse();
        parse_ph    = PH_VERSION;
        field_cnt   = '0;
        acc         = '0;
        topics_left = '0;
        parts_left  = '0;
        name_left   = '0;
        topic_idx   = '0;
    endfunction

    function automatic bit field_done(input logic [ByteW-1:0] b, input int n);
        acc = {acc[WordW-9:0], b};
        if (field_cnt + 1 >= n) begin
            field_cnt = '0;
            return 1'b1;
        end
        field_cnt = field_cnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic void end_topic();
        topic_idx   = topic_idx + 1;
        topics_left = topics_left - 1;
        parse_ph    = (topics_left == 0) ? PH_DONE : PH_NAME_LEN;
    endfunction

    function automatic t_result parse_byte(input logic [ByteW-1:0] b, input logic lst);
        t_result r;
        r = '0;
        case (parse_ph)
            PH_VERSION: if (field_done(b, 2)) begin
                r.have   = 1'b1;
                r.kind   = K_VERSION;
                r.value  = {16'h0, acc[HalfW-1:0]};
                acc      = '0;
                parse_ph = PH_TOPIC_CNT;
            end
            PH_TOPIC_CNT: if (field_done(b, 4)) begin
                topics_left = acc;
                acc         = '0;
                topic_idx   = '0;
                parse_ph    = (topics_left == 0) ? PH_DONE : PH_NAME_LEN;
            end
            PH_NAME_LEN: if (field_done(b, 2)) begin
                name_left = acc[HalfW-1:0];
                acc       = '0;
                parse_ph  = (name_left == 0) ? PH_PART_CNT : PH_NAME;
            end
            PH_NAME: begin
                r.have    = 1'b1;
                r.kind    = K_NAME;
                r.value   = {24'h0, b};
                r.topic   = topic_idx;
                name_left = name_left - 1;
                if (name_left == 0) parse_ph = PH_PART_CNT;
            end
            PH_PART_CNT: if (field_done(b, 4)) begin
                parts_left = acc;
                acc        = '0;
                if (parts_left == 0) end_topic();
                else parse_ph = PH_PART;
            end
            PH_PART: if (field_done(b, 4)) begin
                r.have     = 1'b1;
                r.kind     = K_PART;
                r.value    = acc;
                r.topic    = topic_idx;
                acc        = '0;
                parts_left = parts_left - 1;
                if (parts_left == 0) end_topic();
            end
            default: ;
        endcase
        if (lst) begin
            if (parse_ph != PH_DONE) begin
                r.have  = 1'b1;
                r.kind  = K_MALFORMED;
                r.value = '0;
                r.topic = '0;
            end else if (!r.have) begin
                r.have  = 1'b1;
                r.kind  = K_COMPLETE;
                r.value = '0;
                r.topic = '0;
            end
            clear_parse();
        end
        r.last = lst;
        return r;
    endfunction

    // big-endian field into the message under construction
    function automatic void put_field(input logic [WordW-1:0] v, input int n);
        for (int k = n - 1; k >= 0; k--) msg_q.push_back(v[8*k +: 8]);
    endfunction

    function automatic void compose_message();
        int topics;
        int nlen;
        int parts;
        msg_q.delete();
        put_field($urandom_range(0, 16'hFFFF), 2);
        topics = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        put_field(topics, 4);
        repeat (topics) begin
            case ($urandom_range(0, 9))
                0, 1: nlen = 0;
                2: nlen = $urandom_range(5, 24);
                default: nlen = $urandom_range(1, 4);
            endcase
            put_field(nlen, 2);
            repeat (nlen) msg_q.push_back(8'($urandom));
            parts = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
            put_field(parts, 4);
            repeat (parts) begin
                if ($urandom_range(0, 4) == 0)
                    put_field($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 4);
                else
                    put_field($urandom, 4);
            end
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
    endfunction

    function automatic void build_stimulus();
        int r;
        t_row w;
        foreach (DIRECTED[i]) msg_words.push_back(DIRECTED[i]);
        while (msg_words.size() < $size(DIRECTED) + RandomWords) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                compose_message();
            end else if (r < 90) begin
                compose_message();
                msg_q = msg_q[0:$urandom_range(1, msg_q.size() - 1) - 1];
            end else begin
                msg_q.delete();
                repeat ($urandom_range(1, 10)) msg_q.push_back(8'($urandom));
            end
            foreach (msg_q[k]) begin
                w       = '0;
                w.data  = msg_q[k];
                w.last  = (k == msg_q.size() - 1);
                msg_words.push_back(w);
            end
        end
    endfunction

    function automatic int send_gap();
        int r;
        if (send_rush > 0) begin
            send_rush--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) send_rush = $urandom_range(30, 80);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.have  = 1'b1;
                got.kind  = t_kind'(m_axis_tuser);
                got.value = m_axis_tdata[WordW-1:0];
                got.topic = m_axis_tdata[OutDataW-1:WordW];
                got.last  = m_axis_tlast;
                if (results_due.size() == 0) begin
                    $error("unexpected word: kind %0d value %0h topic %0h last %0b",
                           got.kind, got.value, got.topic, got.last);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (got.kind != want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.value != want.value) begin
                        $error("value: expected %0h, got %0h", want.value, got.value);
                        errors++;
                    end
                    if (got.topic != want.topic) begin
                        $error("topic_number: expected %0h, got %0h", want.topic, got.topic);
                        errors++;
                    end
                    if (got.last != want.last) begin
                        $error("message_end: expected %0b, got %0b", want.last, got.last);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = parse_byte(s_axis_tdata, s_axis_tlast);
                if (msg_words[words_taken].typed) begin
                    want.have  = msg_words[words_taken].have;
                    want.kind  = msg_words[words_taken].kind;
                    want.value = msg_words[words_taken].value;
                    want.topic = msg_words[words_taken].topic;
                    want.last  = msg_words[words_taken].last;
                    pred = want;
                end
                if (pred.have) results_due.push_back(pred);
                words_taken++;
            end
        end
    end

    initial begin : stimulus
        int n;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        words_taken   = 0;
        errors        = 0;
        send_rush     = 0;
        clear_parse();
        build_stimulus();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (msg_words[i]) begin
            n = send_gap();
            if (n > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= msg_words[i].data;
            s_axis_tlast  <= msg_words[i].last;
            do @(posedge i_clk); while (!s_axis_tready);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
        while (words_taken < msg_words.size() || results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : sink
        int  hold;
        int  rush;
        int  r;
        bit  squeezed;
        hold          = 0;
        rush          = 0;
        squeezed      = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!squeezed && words_taken >= 60) begin
                // long back-pressure so the input side has to stall
                squeezed = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (80) @(negedge i_clk);
            end else if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (rush > 0) begin
                rush--;
                m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) hold = $urandom_range(8, 30);
                else if (r < 8) rush = $urandom_range(20, 60);
                m_axis_tready <= (r >= 30);
            end
        end
    end

    initial begin : watchdog
        #(2_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
